FILE: rtl/at_send_response_watcher_macros.svh
// ----------------------------------------------------------------------------
// at_send_response_watcher_macros
// assertion macros used by the send response watcher controller
// ----------------------------------------------------------------------------
`ifndef AT_SEND_RESPONSE_WATCHER_MACROS_SVH
`define AT_SEND_RESPONSE_WATCHER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define AT_ASSERT_IMPL(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define AT_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/at_srw_pkg.sv
// ----------------------------------------------------------------------------
// at_srw_pkg
// shared constants, codes and types of the send response watcher
// ----------------------------------------------------------------------------
package at_srw_pkg;

	localparam int REPLY_CAPACITY_DEF = 512;
	localparam int TICK_BITS_DEF      = 16;
	localparam int CFG_W              = 16;
	localparam int WIN_DEPTH          = 10;

	localparam logic [CFG_W-1:0] PROMPT_LIMIT_RST = 16'd3000;
	localparam logic [CFG_W-1:0] OK_LIMIT_RST     = 16'd5000;

	// register indexes
	localparam logic CFG_PROMPT_LIMIT = 1'b0;
	localparam logic CFG_OK_LIMIT     = 1'b1;

	// action codes
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_BYTE = 2'd1;
	localparam logic [1:0] ACT_REQ  = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_NONE      = 3'd0;
	localparam status_t ST_SENT      = 3'd1;
	localparam status_t ST_LINK_LOST = 3'd2;
	localparam status_t ST_PROMPT_TO = 3'd3;
	localparam status_t ST_OK_TO     = 3'd4;
	localparam status_t ST_BUSY      = 3'd5;
	localparam status_t ST_NO_LINK   = 3'd6;

	// seen flag bits
	localparam int F_PROMPT = 0;
	localparam int F_LINK   = 1;
	localparam int F_ERROR  = 2;
	localparam int F_OK     = 3;

	// reply patterns, first character in the top byte
	localparam logic [7:0]  PAT_PROMPT = ">";
	localparam logic [87:0] PAT_LINK   = "link is not";
	localparam logic [39:0] PAT_ERROR  = "ERROR";
	localparam logic [15:0] PAT_OK     = "OK";

	typedef struct packed {
		logic    command_go;
		logic    payload_go;
		status_t status;
		logic    busy_res;
	} res_t;

	typedef struct packed {
		logic take;
		logic clear;
	} win_ctl_t;

endpackage

FILE: rtl/at_srw_window.sv
// ----------------------------------------------------------------------------
// at_srw_window
// reply window: last ten bytes, stored count, sticky pattern flags
// ----------------------------------------------------------------------------
module at_srw_window #(
	parameter int REPLY_CAPACITY = at_srw_pkg::REPLY_CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  at_srw_pkg::win_ctl_t win_ctl,
	input  logic [7:0]           rx_byte,
	output logic [3:0]           flags
);
	import at_srw_pkg::*;

	localparam int CNT_W = $clog2(REPLY_CAPACITY);

	logic [WIN_DEPTH-1:0][7:0] recent_q;
	logic [CNT_W-1:0]          count_q;
	logic [3:0]                flags_q;
	logic                      term_q;
	logic                      can_take;
	logic                      do_match;
	logic [3:0]                hits;

	assign can_take = !term_q && (count_q < CNT_W'(REPLY_CAPACITY - 1));
	assign do_match = win_ctl.take && can_take && (rx_byte != 8'd0);

	always_comb begin
		hits           = '0;
		hits[F_PROMPT] = (rx_byte == PAT_PROMPT);
		hits[F_LINK]   = ({recent_q, rx_byte} == PAT_LINK);
		hits[F_ERROR]  = ({recent_q[3:0], rx_byte} == PAT_ERROR);
		hits[F_OK]     = ({recent_q[0], rx_byte} == PAT_OK);
	end

	// flags as they stand after this byte
	assign flags = flags_q | (hits & {4{do_match}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			count_q  <= '0;
			flags_q  <= '0;
			term_q   <= 1'b0;
		end else if (win_ctl.clear) begin
			recent_q <= '0;
			count_q  <= '0;
			flags_q  <= '0;
			term_q   <= 1'b0;
		end else if (win_ctl.take && can_take) begin
			count_q <= count_q + 1'b1;
			if (rx_byte == 8'd0) begin
				term_q <= 1'b1;
			end else begin
				flags_q  <= flags;
				recent_q <= {recent_q[WIN_DEPTH-2:0], rx_byte};
			end
		end
	end

endmodule

FILE: rtl/at_srw_ctrl.sv
// ----------------------------------------------------------------------------
// at_srw_ctrl
// exchange sequencer: phase, tick counter, limits and result decode
// ----------------------------------------------------------------------------
module at_srw_ctrl #(
	parameter int TICK_BITS = at_srw_pkg::TICK_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [at_srw_pkg::CFG_W-1:0]     cfg_data,
	input  logic                             step,
	input  logic [1:0]                       action,
	input  logic                             link_ok,
	input  logic [3:0]                       flags,
	output at_srw_pkg::win_ctl_t             win_ctl,
	output at_srw_pkg::res_t                 res
);
	import at_srw_pkg::*;

	`include "at_send_response_watcher_macros.svh"

	localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_PROMPT = 2'd1;
	localparam logic [1:0] PH_OK     = 2'd2;

	logic [1:0]           phase_q, phase_d;
	logic [TICK_BITS-1:0] ticks_q, ticks_d;
	logic [CFG_W-1:0]     prompt_limit_q, ok_limit_q;
	logic [CMP_W-1:0]     lim_x, ticks_x;
	logic                 take, clear;

	assign lim_x   = CMP_W'((phase_q == PH_PROMPT) ? prompt_limit_q : ok_limit_q);
	assign ticks_x = CMP_W'(ticks_q);

	always_comb begin
		phase_d        = phase_q;
		ticks_d        = ticks_q;
		take           = 1'b0;
		clear          = 1'b0;
		res            = '0;
		res.status     = ST_NONE;
		case (action)
			ACT_REQ: begin
				if (phase_q != PH_IDLE) begin
					res.status = ST_BUSY;
				end else if (!link_ok) begin
					res.status = ST_NO_LINK;
				end else begin
					clear          = 1'b1;
					ticks_d        = '0;
					phase_d        = PH_PROMPT;
					res.command_go = 1'b1;
				end
			end
			ACT_BYTE: begin
				if (phase_q == PH_PROMPT) begin
					take = 1'b1;
					if (flags[F_PROMPT]) begin
						clear          = 1'b1;
						ticks_d        = '0;
						phase_d        = PH_OK;
						res.payload_go = 1'b1;
					end else if (flags[F_LINK] || flags[F_ERROR]) begin
						phase_d    = PH_IDLE;
						res.status = ST_LINK_LOST;
					end
				end else if (phase_q == PH_OK) begin
					take = 1'b1;
					if (flags[F_OK]) begin
						phase_d    = PH_IDLE;
						res.status = ST_SENT;
					end
				end
			end
			ACT_TICK: begin
				if (phase_q == PH_PROMPT || phase_q == PH_OK) begin
					if (ticks_x >= lim_x) begin
						res.status = (phase_q == PH_PROMPT) ? ST_PROMPT_TO : ST_OK_TO;
						phase_d    = PH_IDLE;
					end else if (ticks_q != {TICK_BITS{1'b1}}) begin
						ticks_d = ticks_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.busy_res = (phase_d != PH_IDLE);
	end

	assign win_ctl.take  = step && take;
	assign win_ctl.clear = step && clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prompt_limit_q <= PROMPT_LIMIT_RST;
			ok_limit_q     <= OK_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROMPT_LIMIT: prompt_limit_q <= cfg_data;
				CFG_OK_LIMIT:     ok_limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	`AT_ASSERT_IMPL(a_pay_from_prompt, step && res.payload_go, phase_q == PH_PROMPT)
	`AT_ASSERT_NEXT(a_cmd_opens_prompt, step && res.command_go,
		phase_q == PH_PROMPT && ticks_q == '0)
	`AT_ASSERT_NEXT(a_pay_opens_ok, step && res.payload_go, phase_q == PH_OK && ticks_q == '0)
	`AT_ASSERT_IMPL(a_busy_keeps_phase, step && res.status == ST_BUSY, phase_d == phase_q)

endmodule

FILE: rtl/at_send_response_watcher.sv
// ----------------------------------------------------------------------------
// at_send_response_watcher
// send exchange watcher for a serial modem: request, prompt, payload, OK
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and gives exactly
// one result item for each. An accepted item sits in the input register,
// where the phase logic and the ten-byte reply window compare decide its
// result, and the result register holds it for the output side. The input
// takes a new item while a result waits, as long as the input register moves
// on. Reset clears the reply window itself, so there is no clearing pass after
// reset. The user must write limits through cfg_we/cfg_index/cfg_data only
// while no exchange item is in flight; the block does not enforce this.
module at_send_response_watcher #(
	parameter int REPLY_CAPACITY = at_srw_pkg::REPLY_CAPACITY_DEF,
	parameter int TICK_BITS      = at_srw_pkg::TICK_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // action[1:0], rx_byte[9:2], link_ok[10]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,  // command_go[0], payload_go[1],
	                                               // status[4:2], busy_res[5]
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [at_srw_pkg::CFG_W-1:0] cfg_data
);
	import at_srw_pkg::*;

	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] rx_byte_s1;
	logic       link_ok_s1;
	logic       m_valid_q;
	res_t       res_q;
	res_t       res;
	win_ctl_t   win_ctl;
	logic [3:0] flags;
	logic       advance;
	logic       step;

	assign advance  = !m_valid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1  <= s_tdata[1:0];
			rx_byte_s1 <= s_tdata[9:2];
			link_ok_s1 <= s_tdata[10];
		end
		if (step) res_q <= res;
	end

	at_srw_window #(
		.REPLY_CAPACITY(REPLY_CAPACITY)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.win_ctl (win_ctl),
		.rx_byte (rx_byte_s1),
		.flags   (flags)
	);

	at_srw_ctrl #(
		.TICK_BITS(TICK_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.action    (action_s1),
		.link_ok   (link_ok_s1),
		.flags     (flags),
		.win_ctl   (win_ctl),
		.res       (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, res_q.busy_res, res_q.status, res_q.payload_go, res_q.command_go};

endmodule

FILE: bench/at_send_response_watcher_chk.sv
// ----------------------------------------------------------------------------
// at_send_response_watcher_chk
// Watches both stream channels and the register port of the send response
// watcher. It keeps its own copy of the exchange state and the limits,
// predicts the result of every accepted item, and compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module at_send_response_watcher_chk #(
	parameter int REPLY_CAPACITY = at_srw_pkg::REPLY_CAPACITY_DEF,
	parameter int TICK_BITS      = at_srw_pkg::TICK_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [15:0]                  s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [7:0]                   m_tdata,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [at_srw_pkg::CFG_W-1:0] cfg_data,
	output int                           fault_count,
	output int                           results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	import at_srw_pkg::*;

	typedef enum logic [1:0] {XCH_IDLE, XCH_PROMPT, XCH_OK} xch_phase_t;

	xch_phase_t           xch;
	logic [TICK_BITS-1:0] ticks;
	int                   stored;
	logic [7:0]           window [WIN_DEPTH];
	logic [3:0]           seen;
	logic                 halted;
	logic [CFG_W-1:0]     prompt_lim;
	logic [CFG_W-1:0]     ok_lim;
	res_t                 awaited_res [$];
	res_t                 want;
	res_t                 got;

	function automatic bit tail_match(logic [87:0] pat, int len, logic [7:0] c);
		int i;
		if (pat[7:0] != c) return 1'b0;
		for (i = 1; i < len; i++) begin
			if (window[i-1] != pat[8*i +: 8]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void clear_reply();
		int k;
		stored = 0;
		for (k = 0; k < WIN_DEPTH; k++) window[k] = 8'h00;
		seen = 4'h0;
		halted = 1'b0;
	endfunction

	function automatic void absorb_byte(logic [7:0] c);
		int i;
		if (halted || stored >= REPLY_CAPACITY - 1) return;
		stored++;
		if (c == 8'h00) begin
			halted = 1'b1;
			return;
		end
		if (tail_match({80'd0, PAT_PROMPT}, 1, c)) seen[F_PROMPT] = 1'b1;
		if (tail_match(PAT_LINK, 11, c)) seen[F_LINK] = 1'b1;
		if (tail_match({48'd0, PAT_ERROR}, 5, c)) seen[F_ERROR] = 1'b1;
		if (tail_match({72'd0, PAT_OK}, 2, c)) seen[F_OK] = 1'b1;
		for (i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
		window[0] = c;
	endfunction

	function automatic res_t step_exchange(logic [1:0] act, logic [7:0] c, logic link);
		res_t             r;
		logic [CFG_W-1:0] lim;
		r = '0;
		case (act)
			ACT_REQ: begin
				if (xch != XCH_IDLE) begin
					r.status = ST_BUSY;
				end else if (!link) begin
					r.status = ST_NO_LINK;
				end else begin
					clear_reply();
					ticks = '0;
					xch = XCH_PROMPT;
					r.command_go = 1'b1;
				end
			end
			ACT_BYTE: begin
				if (xch == XCH_PROMPT) begin
					absorb_byte(c);
					if (seen[F_PROMPT]) begin
						clear_reply();
						ticks = '0;
						xch = XCH_OK;
						r.payload_go = 1'b1;
					end else if (seen[F_LINK] || seen[F_ERROR]) begin
						xch = XCH_IDLE;
						r.status = ST_LINK_LOST;
					end
				end else if (xch == XCH_OK) begin
					absorb_byte(c);
					if (seen[F_OK]) begin
						xch = XCH_IDLE;
						r.status = ST_SENT;
					end
				end
			end
			ACT_TICK: begin
				if (xch != XCH_IDLE) begin
					lim = (xch == XCH_PROMPT) ? prompt_lim : ok_lim;
					if (ticks >= lim) begin
						r.status = (xch == XCH_PROMPT) ? ST_PROMPT_TO : ST_OK_TO;
						xch = XCH_IDLE;
					end else if (ticks != {TICK_BITS{1'b1}}) begin
						ticks++;
					end
				end
			end
			default: ;
		endcase
		r.busy_res = (xch != XCH_IDLE);
		return r;
	endfunction

	function automatic void check_field(string name, logic [2:0] exp_v, logic [2:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			fault_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xch = XCH_IDLE;
			ticks = '0;
			clear_reply();
			prompt_lim = PROMPT_LIMIT_RST;
			ok_lim = OK_LIMIT_RST;
			awaited_res.delete();
			fault_count = 0;
			results_owed <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.command_go = m_tdata[0];
				got.payload_go = m_tdata[1];
				got.status = m_tdata[4:2];
				got.busy_res = m_tdata[5];
				if (awaited_res.size() == 0) begin
					$display("%0t ns: unexpected result item, expected none, got %h",
						$time, m_tdata);
					fault_count++;
				end else begin
					want = awaited_res.pop_front();
					check_field("command_go", want.command_go, got.command_go);
					check_field("payload_go", want.payload_go, got.payload_go);
					check_field("status", want.status, got.status);
					check_field("busy_res", want.busy_res, got.busy_res);
				end
			end
			if (s_tvalid && s_tready) begin
				awaited_res.push_back(step_exchange(s_tdata[1:0], s_tdata[9:2], s_tdata[10]));
			end
			if (cfg_we) begin
				if (cfg_index == CFG_PROMPT_LIMIT) prompt_lim = cfg_data;
				else ok_lim = cfg_data;
			end
			results_owed <= awaited_res.size();
		end
	end

endmodule

FILE: bench/at_send_response_watcher_tb.sv
// ----------------------------------------------------------------------------
// at_send_response_watcher_tb
// Drives send requests, reply bytes and ticks into the send response watcher
// with random gaps and random output stalls. A short directed run is
// followed by phases of random exchanges under several limit settings,
// including the full reply window, and the checker gives the verdict count.
// ----------------------------------------------------------------------------
module at_send_response_watcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import at_srw_pkg::*;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int         PHASE_ITEMS  = 70;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             cfg_we = 1'b0;
	logic             cfg_index = CFG_PROMPT_LIMIT;
	logic [CFG_W-1:0] cfg_data = '0;

	int               fault_count;
	int               results_owed;
	int               sent_items = 0;
	bit               quiet_tx = 1'b0;
	bit               quiet_rx = 1'b0;
	bit               zero_ok = 1'b0;
	logic [CFG_W-1:0] prompt_lim = PROMPT_LIMIT_RST;
	logic [CFG_W-1:0] ok_lim = OK_LIMIT_RST;
	string            reply_alphabet = "OKERlinks ot\r\nAT+CIPSEND=01";

	always #5 clk = ~clk;

	at_send_response_watcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	at_send_response_watcher_chk watcher_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fault_count  (fault_count),
		.results_owed (results_owed)
	);

	function automatic logic [7:0] reply_char();
		if ($urandom_range(0, 3) == 0) begin
			return zero_ok ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255));
		end
		return reply_alphabet[$urandom_range(0, reply_alphabet.len() - 1)];
	endfunction

	function automatic int tick_run(logic [CFG_W-1:0] lim);
		return (lim < 40) ? int'(lim) + 1 : int'($urandom_range(0, 12));
	endfunction

	task automatic push_item(logic [1:0] act, logic [7:0] c, logic link);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, link, c, act};
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	task automatic send_byte(logic [7:0] c);
		push_item(ACT_BYTE, c, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic send_filler(int n, bit letters);
		int i;
		for (i = 0; i < n; i++) begin
			send_byte(letters ? 8'(8'h61 + $urandom_range(0, 25)) : reply_char());
		end
	endtask

	task automatic send_ticks(int n);
		int i;
		for (i = 0; i < n; i++) push_item(ACT_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic open_exchange();
		push_item(ACT_REQ, 8'($urandom), 1'b1);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic write_limits(logic [CFG_W-1:0] p, logic [CFG_W-1:0] o);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PROMPT_LIMIT;
		cfg_data <= p;
		@(posedge clk);
		cfg_index <= CFG_OK_LIMIT;
		cfg_data <= o;
		@(posedge clk);
		cfg_we <= 1'b0;
		prompt_lim = p;
		ok_lim = o;
		zero_ok = (p <= 40) && (o <= 40);
	endtask

	// prompt matched as the last storable byte, then OK arriving one byte
	// too late in the ok wait, ended by timeout
	task automatic run_window_fill();
		quiet_tx = 1'($urandom_range(0, 1));
		open_exchange();
		send_filler(REPLY_CAPACITY_DEF - 2, 1'b1);
		send_text(">");
		send_filler(REPLY_CAPACITY_DEF - 2, 1'b1);
		send_text("OK");
		send_ticks(int'(ok_lim) + 1);
	endtask

	task automatic run_scenario();
		int kind;
		int i;
		kind = $urandom_range(0, 9);
		quiet_tx = ($urandom_range(0, 5) == 0);
		quiet_rx = ($urandom_range(0, 5) == 0);
		if (kind == 7 && !zero_ok) kind = 8;
		case (kind)
			0, 1, 2, 3: begin
				if ($urandom_range(0, 3) == 0) push_item(ACT_REQ, 8'($urandom), 1'b0);
				open_exchange();
				if ($urandom_range(0, 3) == 0) open_exchange();
				send_filler($urandom_range(0, 8), 1'b0);
				send_ticks($urandom_range(0, 3));
				send_text(">");
				send_filler($urandom_range(0, 6), 1'b0);
				if ($urandom_range(0, 3) == 0) send_text("ERROR");
				if ($urandom_range(0, 3) == 0) send_text("link is not");
				send_ticks($urandom_range(0, 3));
				if ($urandom_range(0, 3) == 0) open_exchange();
				send_text("OK");
			end
			4: begin
				open_exchange();
				send_filler($urandom_range(0, 6), 1'b0);
				if ($urandom_range(0, 1) != 0) send_text("ERROR");
				else send_text("link is not");
			end
			5: begin
				open_exchange();
				send_filler($urandom_range(0, 4), 1'b0);
				send_ticks(tick_run(prompt_lim));
			end
			6: begin
				open_exchange();
				send_text(">");
				send_filler($urandom_range(0, 3), 1'b0);
				send_ticks(tick_run(ok_lim));
			end
			7: begin
				open_exchange();
				send_filler($urandom_range(0, 4), 1'b0);
				send_byte(8'h00);
				send_text(">OK");
				send_ticks(tick_run(prompt_lim));
			end
			8: begin
				for (i = $urandom_range(3, 10); i > 0; i--) begin
					push_item(2'($urandom_range(0, 3)), reply_char(), 1'($urandom_range(0, 1)));
				end
			end
			default: begin
				open_exchange();
				send_text("ERROlink is n0t>O KOOK");
			end
		endcase
		if ($urandom_range(0, 11) == 0) drain_results();
	endtask

	initial begin
		int stall;
		forever begin
			stall = quiet_rx ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int target;
		int p;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle items, unused action, refusals, prompt, error text in ok wait, OK, error text in prompt wait
		push_item(ACT_TICK, 8'h00, 1'b0);
		push_item(ACT_BYTE, 8'hFF, 1'b1);
		push_item(ACT_BYTE, 8'h00, 1'b0);
		push_item(ACT_UNUSED, 8'hAA, 1'b1);
		push_item(ACT_REQ, 8'h55, 1'b0);
		push_item(ACT_REQ, 8'h00, 1'b1);
		push_item(ACT_REQ, 8'hFF, 1'b1);
		push_item(ACT_TICK, 8'h00, 1'b1);
		send_text(">ERROR");
		send_text("OK");
		push_item(ACT_REQ, 8'h00, 1'b1);
		send_text("ERROR");

		for (p = 0; p < 6; p++) begin
			// close an exchange stuck after a zero byte before limits grow
			if (zero_ok) send_ticks(int'(prompt_lim > ok_lim ? prompt_lim : ok_lim) + 1);
			case (p)
				1: write_limits('0, '0);
				2: write_limits(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)));
				3: write_limits('1, '1);
				4: write_limits(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 30)));
				5: write_limits('1, '0);
				default: ;
			endcase
			if (p == 2) run_window_fill();
			target = sent_items + PHASE_ITEMS;
			while (sent_items < target) run_scenario();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fault_count == 0) begin
			$display("at_send_response_watcher verification clean");
		end else begin
			$display("at_send_response_watcher verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("at_send_response_watcher verification failed");
		$finish;
	end

endmodule
